[hdl/hrot_pkg.sv]
// hrot_pkg: shared types, constants and codes for the hash range owner table
// used by hrot_cell, hrot_resolve and hash_range_owner_table_unit
`default_nettype none

package hrot_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int HASH_BITS     = 32;
    localparam int OWNER_BITS    = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // compare lanes carried through the chain
    localparam int NUM_PAIRS = 4;
    localparam int PAIR_OLD  = 0;
    localparam int PAIR_LOW  = 1;
    localparam int PAIR_HIGH = 2;
    localparam int PAIR_NEW  = 3;

    // lowest free entries collected by the scan
    localparam int NUM_FREE = 3;
    localparam int FCNT_W   = $clog2(NUM_FREE + 1);

    // write ports applied in this order, later ports win
    localparam int NUM_WR  = 3;
    localparam int WR_LOW  = 0;
    localparam int WR_HIGH = 1;
    localparam int WR_NEW  = 2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_SPLIT  = 2'd1,
        OP_MERGE  = 2'd2,
        OP_PLACE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_NOT_SUBSET = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef logic [HASH_BITS-1:0]  t_hash;
    typedef logic [OWNER_BITS-1:0] t_owner;
    typedef logic [IDX_W-1:0]      t_idx;

    typedef struct packed {
        logic [1:0] operation;
        t_hash      hash_value;
        t_hash      old_first;
        t_hash      old_end;
        t_hash      new_first;
        t_hash      new_end;
        t_owner     new_owner;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        t_owner     owner_found;
    } t_out;

    typedef struct packed {
        t_hash                   hash;
        t_hash [NUM_PAIRS-1:0]   first;
        t_hash [NUM_PAIRS-1:0]   limit;
    } t_qry;

    typedef struct packed {
        logic                    lk_hit;
        t_owner                  lk_owner;
        logic [NUM_PAIRS-1:0]    hit;
        t_idx [NUM_PAIRS-1:0]    idx;
        t_owner                  old_owner;
        logic [FCNT_W-1:0]       fcnt;
        t_idx [NUM_FREE-1:0]     free_idx;
    } t_tok;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_hash  first;
        t_hash  limit;
        t_owner owner;
    } t_wr_port;

    typedef struct packed {
        t_wr_port [NUM_WR-1:0] port;
        logic                  clr_en;
        t_idx                  clr_idx;
    } t_wr;

endpackage

`default_nettype wire

[hdl/hrot_cell.sv]
// hrot_cell: one table entry plus one stage of the scan token chain
// depends on hrot_pkg
`default_nettype none

module hrot_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hrot_pkg::t_idx i_cell_idx,
    input  wire hrot_pkg::t_qry i_qry,
    input  wire hrot_pkg::t_tok i_tok,
    output hrot_pkg::t_tok      o_tok,
    input  wire hrot_pkg::t_wr  i_wr
);

    logic            r_valid;
    hrot_pkg::t_hash r_first;
    hrot_pkg::t_hash r_limit;
    hrot_pkg::t_owner r_owner;

    logic            n_valid;
    hrot_pkg::t_hash n_first;
    hrot_pkg::t_hash n_limit;
    hrot_pkg::t_owner n_owner;

    hrot_pkg::t_tok  r_tok;
    hrot_pkg::t_tok  n_tok;
    logic            contains;

    // entry update from the write bus
    always_comb begin
        n_valid = r_valid;
        n_first = r_first;
        n_limit = r_limit;
        n_owner = r_owner;
        if (i_wr.clr_en && i_wr.clr_idx == i_cell_idx) begin
            n_valid = 1'b0;
        end
        for (int p = 0; p < hrot_pkg::NUM_WR; p++) begin
            if (i_wr.port[p].en && i_wr.port[p].idx == i_cell_idx) begin
                n_valid = 1'b1;
                n_first = i_wr.port[p].first;
                n_limit = i_wr.port[p].limit;
                n_owner = i_wr.port[p].owner;
            end
        end
    end

    // wrapping range when first exceeds limit
    always_comb begin
        if (r_first <= r_limit) begin
            contains = (i_qry.hash >= r_first) && (i_qry.hash < r_limit);
        end else begin
            contains = (i_qry.hash >= r_first) || (i_qry.hash < r_limit);
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (r_valid) begin
            for (int q = 0; q < hrot_pkg::NUM_PAIRS; q++) begin
                if (!i_tok.hit[q] && r_first == i_qry.first[q]
                        && r_limit == i_qry.limit[q]) begin
                    n_tok.hit[q] = 1'b1;
                    n_tok.idx[q] = i_cell_idx;
                    if (q == hrot_pkg::PAIR_OLD) begin
                        n_tok.old_owner = r_owner;
                    end
                end
            end
            if (!i_tok.lk_hit && contains) begin
                n_tok.lk_hit   = 1'b1;
                n_tok.lk_owner = r_owner;
            end
        end else if (i_tok.fcnt < hrot_pkg::FCNT_W'(hrot_pkg::NUM_FREE)) begin
            n_tok.free_idx[i_tok.fcnt] = i_cell_idx;
            n_tok.fcnt                 = i_tok.fcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_limit <= n_limit;
        r_owner <= n_owner;
        r_tok   <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[hdl/hrot_resolve.sv]
// hrot_resolve: turns the finished scan token into a status and table writes
// depends on hrot_pkg
`default_nettype none

module hrot_resolve (
    input  wire hrot_pkg::t_in  i_item,
    input  wire hrot_pkg::t_qry i_qry,
    input  wire hrot_pkg::t_tok i_tok,
    output hrot_pkg::t_out      o_res,
    output hrot_pkg::t_wr       o_wr
);

    hrot_pkg::t_idx              old_i;
    logic [hrot_pkg::FCNT_W-1:0] pos;
    logic [hrot_pkg::FCNT_W:0]   ucnt;
    hrot_pkg::t_idx              u [hrot_pkg::NUM_FREE];
    logic [hrot_pkg::FCNT_W-1:0] k;
    logic                        full;
    logic                        a_act;
    logic                        b_act;
    hrot_pkg::t_idx              slot_a;
    hrot_pkg::t_idx              slot_b;
    hrot_pkg::t_idx              slot_c;

    // lowest free entries once the old entry is released
    always_comb begin
        old_i = i_tok.idx[hrot_pkg::PAIR_OLD];
        pos   = '0;
        for (int m = 0; m < hrot_pkg::NUM_FREE; m++) begin
            if (hrot_pkg::FCNT_W'(m) < i_tok.fcnt && i_tok.free_idx[m] < old_i) begin
                pos = pos + 1'b1;
            end
        end
        for (int m = 0; m < hrot_pkg::NUM_FREE; m++) begin
            if (hrot_pkg::FCNT_W'(m) < pos) begin
                u[m] = i_tok.free_idx[m];
            end else if (hrot_pkg::FCNT_W'(m) == pos) begin
                u[m] = old_i;
            end else begin
                u[m] = i_tok.free_idx[(m == 0) ? 0 : m - 1];
            end
        end
        ucnt = {1'b0, i_tok.fcnt} + (hrot_pkg::FCNT_W + 1)'(1);
    end

    // split piece placement, allocations taken in write order
    always_comb begin
        a_act  = i_item.new_first > i_item.old_first;
        b_act  = i_item.new_end < i_item.old_end;
        k      = '0;
        full   = 1'b0;
        slot_a = u[0];
        slot_b = u[0];
        slot_c = u[0];
        if (a_act) begin
            if (i_tok.hit[hrot_pkg::PAIR_LOW] && i_tok.idx[hrot_pkg::PAIR_LOW] != old_i) begin
                slot_a = i_tok.idx[hrot_pkg::PAIR_LOW];
            end else begin
                if ({1'b0, k} < ucnt) begin
                    slot_a = u[k];
                end else begin
                    full = 1'b1;
                end
                k = k + 1'b1;
            end
        end
        if (b_act) begin
            // both side pieces can name the same bounds
            if (a_act && i_item.new_end == i_item.old_first
                    && i_item.old_end == i_item.new_first) begin
                slot_b = slot_a;
            end else if (i_tok.hit[hrot_pkg::PAIR_HIGH]
                    && i_tok.idx[hrot_pkg::PAIR_HIGH] != old_i) begin
                slot_b = i_tok.idx[hrot_pkg::PAIR_HIGH];
            end else begin
                if ({1'b0, k} < ucnt) begin
                    slot_b = u[k];
                end else begin
                    full = 1'b1;
                end
                k = k + 1'b1;
            end
        end
        if (i_tok.hit[hrot_pkg::PAIR_NEW] && i_tok.idx[hrot_pkg::PAIR_NEW] != old_i) begin
            slot_c = i_tok.idx[hrot_pkg::PAIR_NEW];
        end else if ({1'b0, k} < ucnt) begin
            slot_c = u[k];
        end else begin
            full = 1'b1;
        end
    end

    always_comb begin
        o_res.status      = hrot_pkg::ST_OK;
        o_res.owner_found = '0;
        o_wr              = '0;
        for (int p = 0; p < hrot_pkg::NUM_WR; p++) begin
            o_wr.port[p].first = i_qry.first[p + 1];
            o_wr.port[p].limit = i_qry.limit[p + 1];
            o_wr.port[p].owner = i_tok.old_owner;
        end
        case (hrot_pkg::t_op'(i_item.operation))
            hrot_pkg::OP_LOOKUP: begin
                if (i_tok.lk_hit) begin
                    o_res.owner_found = i_tok.lk_owner;
                end else begin
                    o_res.status = hrot_pkg::ST_NOT_FOUND;
                end
            end
            hrot_pkg::OP_PLACE: begin
                o_wr.port[hrot_pkg::WR_NEW].owner = i_item.new_owner;
                if (i_tok.hit[hrot_pkg::PAIR_NEW]) begin
                    o_wr.port[hrot_pkg::WR_NEW].en  = 1'b1;
                    o_wr.port[hrot_pkg::WR_NEW].idx = i_tok.idx[hrot_pkg::PAIR_NEW];
                end else if (i_tok.fcnt != '0) begin
                    o_wr.port[hrot_pkg::WR_NEW].en  = 1'b1;
                    o_wr.port[hrot_pkg::WR_NEW].idx = i_tok.free_idx[0];
                end else begin
                    o_res.status = hrot_pkg::ST_FULL;
                end
            end
            hrot_pkg::OP_MERGE: begin
                if (!i_tok.hit[hrot_pkg::PAIR_OLD]) begin
                    o_res.status = hrot_pkg::ST_NOT_FOUND;
                end else begin
                    o_wr.clr_en                    = 1'b1;
                    o_wr.clr_idx                   = old_i;
                    o_wr.port[hrot_pkg::WR_NEW].en = 1'b1;
                    if (i_tok.hit[hrot_pkg::PAIR_NEW]
                            && i_tok.idx[hrot_pkg::PAIR_NEW] != old_i) begin
                        o_wr.port[hrot_pkg::WR_NEW].idx = i_tok.idx[hrot_pkg::PAIR_NEW];
                    end else begin
                        o_wr.port[hrot_pkg::WR_NEW].idx = u[0];
                    end
                end
            end
            hrot_pkg::OP_SPLIT: begin
                if (!i_tok.hit[hrot_pkg::PAIR_OLD]) begin
                    o_res.status = hrot_pkg::ST_NOT_FOUND;
                end else if (i_item.new_first < i_item.old_first
                        || i_item.new_end > i_item.old_end) begin
                    o_res.status = hrot_pkg::ST_NOT_SUBSET;
                end else if (full) begin
                    o_res.status = hrot_pkg::ST_FULL;
                end else begin
                    o_wr.clr_en                        = 1'b1;
                    o_wr.clr_idx                       = old_i;
                    o_wr.port[hrot_pkg::WR_LOW].en     = a_act;
                    o_wr.port[hrot_pkg::WR_LOW].idx    = slot_a;
                    o_wr.port[hrot_pkg::WR_HIGH].en    = b_act;
                    o_wr.port[hrot_pkg::WR_HIGH].idx   = slot_b;
                    o_wr.port[hrot_pkg::WR_NEW].en     = 1'b1;
                    o_wr.port[hrot_pkg::WR_NEW].idx    = slot_c;
                    o_wr.port[hrot_pkg::WR_NEW].owner  = i_item.new_owner;
                end
            end
            default: begin
                o_res.status = hrot_pkg::ST_NOT_FOUND;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/hash_range_owner_table_unit.sv]
// hash range owner table: a row of entry cells scanned by a token that moves
// one cell per cycle; an item is scanned through every cell and then applied,
// with the table writes and the result register updated in the apply state;
// a new item is accepted only in the idle state, after the previous one is applied
// the output register lets the next item start while a result waits
// synchronous active-low reset empties the table at once via the valid bits
`default_nettype none

module hash_range_owner_table_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire hrot_pkg::t_in  i_in_item,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output hrot_pkg::t_out      o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    hrot_pkg::t_idx        r_cnt;
    hrot_pkg::t_idx        n_cnt;
    hrot_pkg::t_in         r_item;
    hrot_pkg::t_qry        r_qry;
    hrot_pkg::t_qry        n_qry;
    logic                  r_out_valid;
    logic                  n_out_valid;
    hrot_pkg::t_out        r_out;

    logic                  accept;
    logic                  apply_go;
    hrot_pkg::t_tok        tok_init;
    hrot_pkg::t_tok        tok_chain [hrot_pkg::TABLE_ENTRIES];
    hrot_pkg::t_out        res;
    hrot_pkg::t_wr         wr_res;
    hrot_pkg::t_wr         wr_bus;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign apply_go   = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    // compare lanes: old range, low piece, high piece, new or merged range
    always_comb begin
        n_qry.hash = i_in_item.hash_value;
        n_qry.first[hrot_pkg::PAIR_OLD]  = i_in_item.old_first;
        n_qry.limit[hrot_pkg::PAIR_OLD]  = i_in_item.old_end;
        n_qry.first[hrot_pkg::PAIR_LOW]  = i_in_item.old_first;
        n_qry.limit[hrot_pkg::PAIR_LOW]  = i_in_item.new_first;
        n_qry.first[hrot_pkg::PAIR_HIGH] = i_in_item.new_end;
        n_qry.limit[hrot_pkg::PAIR_HIGH] = i_in_item.old_end;
        if (hrot_pkg::t_op'(i_in_item.operation) == hrot_pkg::OP_MERGE) begin
            n_qry.first[hrot_pkg::PAIR_NEW] = (i_in_item.old_first < i_in_item.new_first)
                                            ? i_in_item.old_first : i_in_item.new_first;
            n_qry.limit[hrot_pkg::PAIR_NEW] = (i_in_item.old_end > i_in_item.new_end)
                                            ? i_in_item.old_end : i_in_item.new_end;
        end else begin
            n_qry.first[hrot_pkg::PAIR_NEW] = i_in_item.new_first;
            n_qry.limit[hrot_pkg::PAIR_NEW] = i_in_item.new_end;
        end
    end

    assign tok_init = '0;

    for (genvar g = 0; g < hrot_pkg::TABLE_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            hrot_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cell_idx (hrot_pkg::IDX_W'(g)),
                .i_qry      (r_qry),
                .i_tok      (tok_init),
                .o_tok      (tok_chain[g]),
                .i_wr       (wr_bus)
            );
        end else begin : g_body
            hrot_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cell_idx (hrot_pkg::IDX_W'(g)),
                .i_qry      (r_qry),
                .i_tok      (tok_chain[g-1]),
                .o_tok      (tok_chain[g]),
                .i_wr       (wr_bus)
            );
        end
    end

    hrot_resolve u_resolve (
        .i_item (r_item),
        .i_qry  (r_qry),
        .i_tok  (tok_chain[hrot_pkg::TABLE_ENTRIES-1]),
        .o_res  (res),
        .o_wr   (wr_res)
    );

    assign wr_bus = apply_go ? wr_res : '0;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                // last cell holds the full token in the cycle after its turn
                if (r_cnt == hrot_pkg::IDX_W'(hrot_pkg::TABLE_ENTRIES - 1)) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
            r_qry  <= n_qry;
        end
        if (apply_go) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
